// File: rtl/symbol_table_cam_assert.svh
// Assertion macros used by the checker in stc_checker.sv.
`ifndef SYMBOL_TABLE_CAM_ASSERT_SVH
`define SYMBOL_TABLE_CAM_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define STC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define STC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// File: rtl/stc_pkg.sv
`timescale 1ns / 1ps

package stc_pkg;

    localparam int KIND_W     = 2;
    localparam int SYMBOL_W   = 64;
    localparam int LOC_PORT_W = 16;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MATCH  = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load;    // latch the incoming transaction, restart the scan
        logic scan;    // walk the used entries
        logic commit;  // update the table and load the result register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
    } dp_status_t;

endpackage

// File: rtl/stc_ctrl.sv
`timescale 1ns / 1ps

module stc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output stc_pkg::dp_cmd_t   cmd,
    input  stc_pkg::dp_status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = aresetn && (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                // hold until the result register can take the new transaction
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: rtl/stc_datapath.sv
`timescale 1ns / 1ps

module stc_datapath #(
    parameter int ENTRIES   = 64,
    parameter int KEY_CHARS = 8,
    parameter int LOC_BITS  = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  stc_pkg::dp_cmd_t                     cmd,
    output stc_pkg::dp_status_t                  status,
    input  logic [stc_pkg::KIND_W-1:0]           s_kind,
    input  logic [stc_pkg::SYMBOL_W-1:0]         s_symbol,
    input  logic [stc_pkg::LOC_PORT_W-1:0]       s_location,
    output logic                                 m_found,
    output logic [stc_pkg::LOC_PORT_W-1:0]       m_found_location,
    output logic                                 m_multiply_defined,
    output logic                                 m_matched,
    output logic                                 m_table_full
);

    localparam int KEY_BITS = 8 * KEY_CHARS;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);

    typedef struct packed {
        logic                mult;
        logic [LOC_BITS-1:0] loc;
        logic [KEY_BITS-1:0] key;
    } word_t;

    word_t mem [ENTRIES];

    // current transaction
    logic [stc_pkg::KIND_W-1:0] kind_reg;
    logic [KEY_BITS-1:0]        key_reg;
    logic [LOC_BITS-1:0]        loc_reg;

    // scan pipeline
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_idx_reg;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    word_t            rd_data_reg;
    logic             issue;

    // hit capture
    logic                hit_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic [LOC_BITS-1:0] hit_loc_reg;
    logic                hit_mult_reg;

    // result register
    logic                           found_reg, found_next;
    logic [stc_pkg::LOC_PORT_W-1:0] found_loc_reg, found_loc_next;
    logic                           mult_reg, mult_next;
    logic                           matched_reg, matched_next;
    logic                           full_reg, full_next;

    // table write port
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    word_t            wr_data;

    logic is_insert, is_match, room;

    assign issue            = cmd.scan && (scan_idx_reg < count_reg);
    assign status.scan_done = (scan_idx_reg == count_reg) && !rd_valid_reg;

    assign is_insert = (kind_reg == stc_pkg::KIND_INSERT);
    assign is_match  = (kind_reg == stc_pkg::KIND_MATCH);
    assign room      = (count_reg < CNT_W'(ENTRIES));

    always_comb begin
        wr_en          = cmd.commit && is_insert && (hit_reg || room);
        wr_addr        = hit_reg ? hit_idx_reg : count_reg[IDX_W-1:0];
        wr_data.key    = key_reg;
        wr_data.loc    = hit_reg ? hit_loc_reg : loc_reg;
        wr_data.mult   = hit_reg;
        count_next     = count_reg;
        if (cmd.commit && is_insert && !hit_reg && room) begin
            count_next = count_reg + CNT_W'(1);
        end

        found_next     = hit_reg;
        found_loc_next = hit_reg ? stc_pkg::LOC_PORT_W'(hit_loc_reg) : '0;
        // a repeated insert marks the entry as multiply defined
        mult_next      = hit_reg && (hit_mult_reg || is_insert);
        matched_next   = is_match && hit_reg && (hit_loc_reg == loc_reg) && !hit_mult_reg;
        full_next      = is_insert && !hit_reg && !room;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_data_reg <= mem[scan_idx_reg[IDX_W-1:0]];
            rd_idx_reg  <= scan_idx_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end else begin
            count_reg    <= count_next;
            rd_valid_reg <= issue;
            if (cmd.load) begin
                scan_idx_reg <= '0;
                hit_reg      <= 1'b0;
            end else begin
                if (issue) begin
                    scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                end
                // keys are unique in the table, so at most one entry hits
                if (rd_valid_reg && (rd_data_reg.key == key_reg)) begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= s_kind;
            key_reg  <= KEY_BITS'(s_symbol);
            loc_reg  <= LOC_BITS'(s_location);
        end
        if (rd_valid_reg && (rd_data_reg.key == key_reg)) begin
            hit_idx_reg  <= rd_idx_reg;
            hit_loc_reg  <= rd_data_reg.loc;
            hit_mult_reg <= rd_data_reg.mult;
        end
        if (cmd.commit) begin
            found_reg     <= found_next;
            found_loc_reg <= found_loc_next;
            mult_reg      <= mult_next;
            matched_reg   <= matched_next;
            full_reg      <= full_next;
        end
    end

    assign m_found            = found_reg;
    assign m_found_location   = found_loc_reg;
    assign m_multiply_defined = mult_reg;
    assign m_matched          = matched_reg;
    assign m_table_full       = full_reg;

endmodule

// File: rtl/symbol_table_cam.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_kind, s_symbol, s_location
// m_        out        m_valid / m_ready  m_found, m_found_location, m_multiply_defined,
//                                         m_matched, m_table_full
//
// The scan reads the N used entries in turn, N being the number of used entries: the
// single read port of the entry memory compares one stored key per cycle.
// A new transaction is taken while the previous result waits in the output register.
// aresetn is synchronous, active low; it empties the table at once.
// A stalled m_ready holds the result and stops the next commit, not the scan.

module symbol_table_cam #(
    parameter int ENTRIES   = 64,
    parameter int KEY_CHARS = 8,
    parameter int LOC_BITS  = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [stc_pkg::KIND_W-1:0]     s_kind,
    input  logic [stc_pkg::SYMBOL_W-1:0]   s_symbol,
    input  logic [stc_pkg::LOC_PORT_W-1:0] s_location,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_found,
    output logic [stc_pkg::LOC_PORT_W-1:0] m_found_location,
    output logic                           m_multiply_defined,
    output logic                           m_matched,
    output logic                           m_table_full
);

    stc_pkg::dp_cmd_t    cmd;
    stc_pkg::dp_status_t status;

    stc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    stc_datapath #(
        .ENTRIES   (ENTRIES),
        .KEY_CHARS (KEY_CHARS),
        .LOC_BITS  (LOC_BITS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .s_kind             (s_kind),
        .s_symbol           (s_symbol),
        .s_location         (s_location),
        .m_found            (m_found),
        .m_found_location   (m_found_location),
        .m_multiply_defined (m_multiply_defined),
        .m_matched          (m_matched),
        .m_table_full       (m_table_full)
    );

endmodule

// File: rtl/stc_checker.sv
`timescale 1ns / 1ps

`include "symbol_table_cam_assert.svh"

module stc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic [stc_pkg::KIND_W-1:0]     s_kind,
    input logic [stc_pkg::SYMBOL_W-1:0]   s_symbol,
    input logic [stc_pkg::LOC_PORT_W-1:0] s_location,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_found,
    input logic [stc_pkg::LOC_PORT_W-1:0] m_found_location,
    input logic                           m_multiply_defined,
    input logic                           m_matched,
    input logic                           m_table_full
);

    logic [stc_pkg::LOC_PORT_W+3:0] m_payload;

    assign m_payload = {m_found, m_found_location, m_multiply_defined, m_matched,
                        m_table_full};

    `STC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_payload))
    `STC_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready)
    `STC_ASSERT_NOW(a_full_clean, m_valid && m_table_full,
                    !m_found && !m_multiply_defined && !m_matched && (m_found_location == '0))
    `STC_ASSERT_NOW(a_match_found, m_valid && m_matched, m_found && !m_multiply_defined)
    `STC_ASSERT_NOW(a_mult_found, m_valid && m_multiply_defined, m_found)

endmodule

bind symbol_table_cam stc_checker u_stc_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int ENTRIES   = 64;
    localparam int KEY_CHARS = 8;
    localparam int LOC_BITS  = 16;
    localparam logic [stc_pkg::SYMBOL_W-1:0] KEY_MASK =
        {stc_pkg::SYMBOL_W{1'b1}} >> (64 - 8 * KEY_CHARS);
    localparam logic [stc_pkg::LOC_PORT_W-1:0] LOC_MASK =
        {stc_pkg::LOC_PORT_W{1'b1}} >> (16 - LOC_BITS);
    // Unassigned operation code, decoded as a lookup
    localparam logic [stc_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEMS_PER_PHASE = 580;
    localparam int DRAIN_CYCLES = ENTRIES + 16;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct packed {
        logic                           found;
        logic [stc_pkg::LOC_PORT_W-1:0] location;
        logic                           multiple;
        logic                           matched;
        logic                           full;
    } cam_result_t;

    class cam_scoreboard;
        bit                           ent_valid[ENTRIES];
        bit [stc_pkg::SYMBOL_W-1:0]   ent_key[ENTRIES];
        bit [stc_pkg::LOC_PORT_W-1:0] ent_loc[ENTRIES];
        bit                           ent_mult[ENTRIES];
        int                           used;
        cam_result_t                  pending[$];
        int                           errors;

        function int find_key(logic [stc_pkg::SYMBOL_W-1:0] key);
            for (int i = 0; i < ENTRIES; i++) begin
                if (ent_valid[i] && ent_key[i] == key)
                    return i;
            end
            return -1;
        endfunction

        function void note_input(logic [stc_pkg::KIND_W-1:0] kind,
                                 logic [stc_pkg::SYMBOL_W-1:0] symbol,
                                 logic [stc_pkg::LOC_PORT_W-1:0] location);
            cam_result_t                    r;
            logic [stc_pkg::SYMBOL_W-1:0]   key;
            logic [stc_pkg::LOC_PORT_W-1:0] loc;
            int                             hit;
            key = symbol & KEY_MASK;
            loc = location & LOC_MASK;
            hit = find_key(key);
            r = '0;
            if (kind == stc_pkg::KIND_INSERT) begin
                if (hit >= 0) begin
                    ent_mult[hit] = 1'b1;
                end else if (used < ENTRIES) begin
                    ent_valid[used] = 1'b1;
                    ent_key[used]   = key;
                    ent_loc[used]   = loc;
                    ent_mult[used]  = 1'b0;
                    used++;
                end else begin
                    r.full = 1'b1;
                end
            end
            if (hit >= 0) begin
                r.found    = 1'b1;
                r.location = ent_loc[hit];
                r.multiple = ent_mult[hit];
                r.matched  = (kind == stc_pkg::KIND_MATCH) && (ent_loc[hit] == loc)
                             && !ent_mult[hit];
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic found, logic [stc_pkg::LOC_PORT_W-1:0] location,
                                   logic multiple, logic matched, logic full);
            cam_result_t e;
            if (pending.size() == 0) begin
                $error("result with no transaction outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (found !== e.found) begin
                $error("found: expected %0d, actual %0d", e.found, found);
                errors++;
            end
            if (location !== e.location) begin
                $error("found_location: expected %0h, actual %0h", e.location, location);
                errors++;
            end
            if (multiple !== e.multiple) begin
                $error("multiply_defined: expected %0d, actual %0d", e.multiple, multiple);
                errors++;
            end
            if (matched !== e.matched) begin
                $error("matched: expected %0d, actual %0d", e.matched, matched);
                errors++;
            end
            if (full !== e.full) begin
                $error("table_full: expected %0d, actual %0d", e.full, full);
                errors++;
            end
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic [stc_pkg::KIND_W-1:0]     s_kind;
    logic [stc_pkg::SYMBOL_W-1:0]   s_symbol;
    logic [stc_pkg::LOC_PORT_W-1:0] s_location;
    logic                           m_valid;
    logic                           m_ready;
    logic                           m_found;
    logic [stc_pkg::LOC_PORT_W-1:0] m_found_location;
    logic                           m_multiply_defined;
    logic                           m_matched;
    logic                           m_table_full;

    cam_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_request;
    int  cycle_count;

    symbol_table_cam #(
        .ENTRIES  (ENTRIES),
        .KEY_CHARS(KEY_CHARS),
        .LOC_BITS (LOC_BITS)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_symbol          (s_symbol),
        .s_location        (s_location),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_found           (m_found),
        .m_found_location  (m_found_location),
        .m_multiply_defined(m_multiply_defined),
        .m_matched         (m_matched),
        .m_table_full      (m_table_full)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Result side: decide ready at the falling edge, take the transaction at the rising edge
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                m_ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_found, m_found_location, m_multiply_defined, m_matched,
                            m_table_full);
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic [stc_pkg::KIND_W-1:0] kind,
                             input logic [stc_pkg::SYMBOL_W-1:0] symbol,
                             input logic [stc_pkg::LOC_PORT_W-1:0] location);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_kind     = kind;
        s_symbol   = symbol;
        s_location = location;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(kind, symbol, location);
        @(negedge aclk);
    endtask

    task automatic pick_item(output logic [stc_pkg::KIND_W-1:0] kind,
                             output logic [stc_pkg::SYMBOL_W-1:0] symbol,
                             output logic [stc_pkg::LOC_PORT_W-1:0] location);
        int roll;
        int idx;
        int nchar;
        bit stored;
        roll = $urandom_range(99);
        nchar = $urandom_range(1, 8);
        symbol = {$urandom, $urandom};
        if ($urandom_range(1))
            symbol = symbol & ({stc_pkg::SYMBOL_W{1'b1}} >> (64 - 8 * nchar));
        location = stc_pkg::LOC_PORT_W'($urandom);
        stored = 1'b0;
        idx = 0;
        if (roll < 25) begin
            kind = stc_pkg::KIND_INSERT;
            // repeat inserts mostly on a few early entries so others stay matchable
            if (sb.used > 0 && $urandom_range(1)) begin
                stored = 1'b1;
                idx = $urandom_range((sb.used < 12 ? sb.used : 12) - 1);
            end
        end else if (roll < 60) begin
            kind = ($urandom_range(9) == 0) ? KIND_SPARE : stc_pkg::KIND_LOOKUP;
            if (sb.used > 0 && $urandom_range(9) < 7) begin
                stored = 1'b1;
                idx = $urandom_range(sb.used - 1);
            end
        end else begin
            kind = stc_pkg::KIND_MATCH;
            if (sb.used > 0 && $urandom_range(3) != 0) begin
                stored = 1'b1;
                idx = $urandom_range(sb.used - 1);
                if ($urandom_range(9) < 6)
                    location = sb.ent_loc[idx];
            end
        end
        if (stored)
            symbol = sb.ent_key[idx];
    endtask

    initial begin
        logic [stc_pkg::KIND_W-1:0]     kind;
        logic [stc_pkg::SYMBOL_W-1:0]   symbol;
        logic [stc_pkg::LOC_PORT_W-1:0] location;
        sb = new;
        send_idle_pct = 20;
        recv_idle_pct = 53;
        hold_request = 1'b0;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_kind     = stc_pkg::KIND_INSERT;
        s_symbol   = '0;
        s_location = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // lookups and matches on an empty table
        send_item(stc_pkg::KIND_LOOKUP, 64'h0, 16'h0);
        send_item(stc_pkg::KIND_MATCH, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        // all-zero key behaves as an ordinary key
        send_item(stc_pkg::KIND_INSERT, 64'h0, 16'hFFFF);
        send_item(stc_pkg::KIND_LOOKUP, 64'h0, 16'h0);
        send_item(stc_pkg::KIND_MATCH, 64'h0, 16'hFFFF);
        send_item(stc_pkg::KIND_MATCH, 64'h0, 16'h7FFF);
        send_item(stc_pkg::KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0);
        send_item(KIND_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h1234);
        send_item(stc_pkg::KIND_MATCH, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0);
        // neighbors differing in a single bit
        send_item(stc_pkg::KIND_INSERT, 64'h1, 16'h1234);
        send_item(stc_pkg::KIND_INSERT, 64'h8000_0000_0000_0000, 16'h8000);
        send_item(stc_pkg::KIND_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 16'h0);
        send_item(stc_pkg::KIND_INSERT, 64'h0000_0000_4C4F_4F50, 16'h0042);
        // repeated insert keeps the first location and sets the mark
        send_item(stc_pkg::KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0005);
        send_item(stc_pkg::KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0);
        send_item(stc_pkg::KIND_MATCH, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0);
        send_item(KIND_SPARE, 64'h0000_0000_4C4F_4F50, 16'h0);
        send_item(stc_pkg::KIND_MATCH, 64'h0000_0000_4C4F_4F50, 16'h0042);
        send_item(stc_pkg::KIND_MATCH, 64'h8000_0000_0000_0000, 16'h8001);
        send_item(stc_pkg::KIND_MATCH, 64'h4153_5345_4D42_4C45, 16'h0);

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 53;
                recv_idle_pct = 20;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // hold results back while items keep coming
                hold_request = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick_item(kind, symbol, location);
                send_item(kind, symbol, location);
            end
        end
        s_valid = 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
